FILE: rtl/edrs_pkg.sv
package edrs_pkg;

  localparam int unsigned RING_SLOTS = 16;
  localparam int unsigned IDX_W      = $clog2(RING_SLOTS);

  localparam logic signed [15:0] DEADLINE_FLOOR = -16'sd30000;
  localparam logic signed [15:0] DEADLINE_CEIL  = 16'sd32767;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_TICK   = 2'd1,
    OP_PICK   = 2'd2,
    OP_FINISH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One ring slot as it sits in the entry memory.
  typedef struct packed {
    logic [14:0]        period;
    logic signed [15:0] deadline;
    logic [7:0]         id;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    op_e                op;
    logic [7:0]         proc_id;
    logic signed [15:0] start_deadline;
    logic [14:0]        period;
    logic               repeat_req;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [7:0]         head_id;
    logic signed [15:0] head_deadline;
    logic               due;
  } res_t;

  // Read and write request from the controller to the entry memory.
  typedef struct packed {
    logic   rd_en;
    idx_t   rd_addr;
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
  } ram_req_t;

  function automatic idx_t ring_next(input idx_t i);
    idx_t r;
    if (i == idx_t'(RING_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

  // Deadline plus period, clipped at the largest positive deadline.
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] d,
                                                 input logic [14:0] p);
    logic signed [16:0] s;
    logic signed [15:0] r;
    s = 17'(d) + $signed({2'b00, p});
    if (s > 17'(DEADLINE_CEIL)) begin
      r = DEADLINE_CEIL;
    end else begin
      r = s[15:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/edrs_ram.sv
module edrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/edrs_ctrl.sv
module edrs_ctrl
  import edrs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  input  cmd_t     cmd_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output res_t     res_o,
  output ram_req_t ram_req_o,
  input  entry_t   ram_rd_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_SCAN,
    S_PICK_SCAN,
    S_PICK_WR_HEAD,
    S_PICK_WR_BEST,
    S_FIN_RD,
    S_FIN_PUSH,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  idx_t   head_q, head_d;
  idx_t   tail_q, tail_d;
  idx_t   rd_ptr_q, rd_ptr_d;
  idx_t   addr_q, addr_d;
  logic   pend_q, pend_d;
  idx_t   best_idx_q, best_idx_d;
  entry_t best_q, best_d;
  entry_t head_ent_q, head_ent_d;
  res_t   res_q, res_d;

  logic   issue;
  logic   ring_empty;
  logic   ring_full;
  entry_t dec_ent;

  assign ring_empty = (head_q == tail_q);
  assign ring_full  = (ring_next(tail_q) == head_q);
  assign issue      = (rd_ptr_q != tail_q);

  always_comb begin
    dec_ent = ram_rd_data_i;
    if (ram_rd_data_i.deadline > DEADLINE_FLOOR) begin
      dec_ent.deadline = ram_rd_data_i.deadline - 16'sd1;
    end
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    rd_ptr_d   = rd_ptr_q;
    addr_d     = addr_q;
    pend_d     = pend_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    head_ent_d = head_ent_q;
    res_d      = res_q;

    ram_req_o         = '0;
    ram_req_o.rd_addr = rd_ptr_q;
    ram_req_o.wr_addr = addr_q;
    ram_req_o.wr_data = dec_ent;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          res_d        = '0;
          res_d.status = ST_OK;
          rd_ptr_d     = head_q;
          pend_d       = 1'b0;
          unique case (cmd_i.op)
            OP_ADD: begin
              if (ring_full) begin
                res_d.status = ST_FULL;
              end else begin
                ram_req_o.wr_en            = 1'b1;
                ram_req_o.wr_addr          = tail_q;
                ram_req_o.wr_data.id       = cmd_i.proc_id;
                ram_req_o.wr_data.deadline = sat_add(cmd_i.start_deadline, cmd_i.period);
                ram_req_o.wr_data.period   = cmd_i.period;
                tail_d                     = ring_next(tail_q);
              end
              state_d = S_RESULT;
            end
            OP_TICK: begin
              state_d = S_TICK_SCAN;
            end
            OP_PICK: begin
              if (ring_empty) begin
                res_d.status = ST_EMPTY;
                state_d      = S_RESULT;
              end else begin
                state_d = S_PICK_SCAN;
              end
            end
            OP_FINISH: begin
              if (ring_empty) begin
                res_d.status = ST_EMPTY;
                state_d      = S_RESULT;
              end else if (cmd_i.repeat_req) begin
                state_d = S_FIN_RD;
              end else begin
                head_d  = ring_next(head_q);
                state_d = S_RESULT;
              end
            end
          endcase
        end
      end
      S_TICK_SCAN, S_PICK_SCAN: begin
        // Read one slot per cycle; the slot read last cycle is handled now.
        ram_req_o.rd_en = issue;
        pend_d          = issue;
        addr_d          = rd_ptr_q;
        if (issue) begin
          rd_ptr_d = ring_next(rd_ptr_q);
        end
        if (pend_q) begin
          if (state_q == S_TICK_SCAN) begin
            ram_req_o.wr_en = 1'b1;
          end else if (addr_q == head_q) begin
            best_d     = ram_rd_data_i;
            head_ent_d = ram_rd_data_i;
            best_idx_d = addr_q;
          end else if (ram_rd_data_i.deadline < best_q.deadline) begin
            best_d     = ram_rd_data_i;
            best_idx_d = addr_q;
          end
        end
        if (!issue) begin
          state_d = (state_q == S_TICK_SCAN) ? S_RESULT : S_PICK_WR_HEAD;
        end
      end
      S_PICK_WR_HEAD: begin
        ram_req_o.wr_en   = 1'b1;
        ram_req_o.wr_addr = head_q;
        ram_req_o.wr_data = best_q;
        state_d           = S_PICK_WR_BEST;
      end
      S_PICK_WR_BEST: begin
        ram_req_o.wr_en     = 1'b1;
        ram_req_o.wr_addr   = best_idx_q;
        ram_req_o.wr_data   = head_ent_q;
        res_d.head_id       = best_q.id;
        res_d.head_deadline = best_q.deadline;
        res_d.due           = (best_q.deadline <= 16'sd0);
        state_d             = S_RESULT;
      end
      S_FIN_RD: begin
        ram_req_o.rd_en   = 1'b1;
        ram_req_o.rd_addr = head_q;
        state_d           = S_FIN_PUSH;
      end
      S_FIN_PUSH: begin
        if (ring_full) begin
          res_d.status = ST_FULL;
        end else begin
          ram_req_o.wr_en            = 1'b1;
          ram_req_o.wr_addr          = tail_q;
          ram_req_o.wr_data          = ram_rd_data_i;
          ram_req_o.wr_data.deadline = sat_add(ram_rd_data_i.deadline,
                                               ram_rd_data_i.period);
          tail_d                     = ring_next(tail_q);
        end
        head_d  = ring_next(head_q);
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q   <= rd_ptr_d;
    addr_q     <= addr_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    head_ent_q <= head_ent_d;
    res_q      <= res_d;
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESULT);
  assign res_o       = res_q;

  // A push never lets the tail run onto the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(tail_q) |-> (tail_q != head_q))
    else $error("tail advanced onto head");

  // Reads and write-backs during a sweep never touch the same slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req_o.rd_en && ram_req_o.wr_en) |-> (ram_req_o.rd_addr != ram_req_o.wr_addr))
    else $error("read and write to the same slot in one cycle");

  // A waiting result stays put until the output side takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && !res_ready_i) |=> (state_q == S_RESULT && $stable(res_q)))
    else $error("pending result lost or changed");

endmodule

FILE: rtl/earliest_deadline_ring_scheduler_unit.sv
// Earliest-deadline ring scheduler.
//
// Commands arrive on the s_axis channel, one per beat: tuser carries the
// operation (add, tick, pick earliest, finish head) and tdata its operands.
// Every command yields exactly one result beat on the m_axis channel with a
// status, and after a successful pick the id and deadline of the new head
// and its due flag. Commands are handled one at a time.
//
// Entries live in one synchronous memory of RING_SLOTS slots. From the
// command beat, add and a plain finish go straight to the result, while
// finish with repeat first reads the head slot back. Tick and pick sweep
// the N stored entries one slot per cycle through the memory read port, and
// pick then writes back the swap of the chosen entry and the old head.
//
// Reset empties the ring by clearing the head and tail indexes; the memory
// itself is not cleared and slots outside the ring are never read. A result
// register sits on the output, so a new command is taken while the previous
// result still waits; a stalled receiver holds the controller only once a
// second result is ready.
module earliest_deadline_ring_scheduler_unit
  import edrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // proc_id[7:0], start_deadline[23:8], period[38:24], repeat_req[39]
  input  logic [39:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], head_id[9:2], head_deadline[25:10], due[26], zero fill above
  output logic [31:0] m_axis_tdata
);

  cmd_t     cmd;
  res_t     res;
  logic     res_valid;
  logic     res_ready;
  ram_req_t ram_req;
  entry_t   ram_rd_data;

  logic        out_valid_q;
  logic [31:0] out_data_q;

  // Unpack the command beat.
  assign cmd.op             = op_e'(s_axis_tuser);
  assign cmd.proc_id        = s_axis_tdata[7:0];
  assign cmd.start_deadline = $signed(s_axis_tdata[23:8]);
  assign cmd.period         = s_axis_tdata[38:24];
  assign cmd.repeat_req     = s_axis_tdata[39];

  edrs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (s_axis_tvalid),
    .cmd_ready_o   (s_axis_tready),
    .cmd_i         (cmd),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .ram_req_o     (ram_req),
    .ram_rd_data_i (ram_rd_data)
  );

  edrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_SLOTS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_req.wr_en),
    .wr_addr_i (ram_req.wr_addr),
    .wr_data_i (ram_req.wr_data),
    .rd_en_i   (ram_req.rd_en),
    .rd_addr_i (ram_req.rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // The output register takes a new result whenever it is empty or being
  // drained in the same cycle.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= {5'b00000, res.due, res.head_deadline, res.head_id, res.status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
